>>> hdl/cau_pkg.sv
// package for the complex arithmetic unit: action codes, status codes,
// controller states and the command/status structs between control and datapath
package cau_pkg;

    typedef enum logic [2:0] {
        ACT_ADD   = 3'd0,
        ACT_SUB   = 3'd1,
        ACT_MUL   = 3'd2,
        ACT_DIV   = 3'd3,
        ACT_EQ    = 3'd4,
        ACT_REQ   = 3'd5,
        ACT_POW   = 3'd6,
        ACT_MOD   = 3'd7
    } action_t;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_DZ  = 2'd1;
    localparam logic [1:0] ST_OVF = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIMPLE,
        S_MUL,
        S_DIV_SETUP,
        S_DIV_ITER,
        S_DIV_DONE,
        S_POW_STEP,
        S_POW_MUL,
        S_SQRT_SETUP,
        S_SQRT_ITER,
        S_OUT
    } state_t;

    // datapath operation commands
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SIMPLE,
        OP_MUL_AB,
        OP_MUL_ZP,
        OP_MUL_PP,
        OP_DIV_SETUP,
        OP_DIV_RECIP,
        OP_DIV_ITER,
        OP_DIV_DONE,
        OP_SQRT_SETUP,
        OP_SQRT_ITER,
        OP_POW_INIT,
        OP_POW_SHIFT
    } op_t;

    typedef struct packed {
        op_t  op;
    } cmd_t;

    typedef struct packed {
        logic iter_done;
        logic div_zero;
        logic exp_bit;
        logic exp_more;
        logic exp_neg;
    } sts_t;

endpackage

>>> hdl/complex_arithmetic_unit.sv
// complex arithmetic unit on signed fixed-point operands, one result per item
// a negative power exponent is followed by a divide that takes the reciprocal
// one item at a time: the next item is accepted the cycle after the result loads
// reset (rst_n low, asynchronous) empties the controller and output valid and clears tol_reg
module complex_arithmetic_unit
    import cau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int EXP_BITS  = 6
)
(
    input  logic        clk,
    input  logic        rst_n,
    // tolerance register write
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // action, a_re, a_im, b_re, b_im, exponent (lowest bit first), zero padded
    input  logic [((3+4*WORD_BITS+EXP_BITS+7)/8)*8-1:0] s_axis_tdata,
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // res_re, res_im, is_equal, status (lowest bit first), zero padded
    output logic [((2*WORD_BITS+3+7)/8)*8-1:0] m_axis_tdata
);

    localparam int W   = WORD_BITS;
    localparam int OW  = ((2*W+3+7)/8)*8;

    logic [15:0] tol_reg;
    logic        busy, done, in_fire;
    cmd_t        cmd;
    sts_t        sts;
    logic signed [W-1:0] res_re, res_im;
    logic        is_equal;
    logic [1:0]  status;
    logic        ovalid_reg;
    logic [OW-1:0] odata_reg;

    // tolerance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tol_reg <= '0;
        else if (cfg_we)
            tol_reg <= cfg_wdata;
    end

    assign s_axis_tready = !busy;
    assign in_fire       = s_axis_tvalid && s_axis_tready;

    cau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_fire  (in_fire),
        .action   (action_t'(s_axis_tdata[2:0])),
        .out_free (!ovalid_reg || m_axis_tready),
        .sts      (sts),
        .cmd      (cmd),
        .busy     (busy),
        .done     (done)
    );

    cau_dp #(
        .WORD_BITS (WORD_BITS),
        .FRAC_BITS (FRAC_BITS),
        .EXP_BITS  (EXP_BITS)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .action   (s_axis_tdata[2:0]),
        .a_re     (s_axis_tdata[3 +: W]),
        .a_im     (s_axis_tdata[3+W +: W]),
        .b_re     (s_axis_tdata[3+2*W +: W]),
        .b_im     (s_axis_tdata[3+3*W +: W]),
        .exponent (s_axis_tdata[3+4*W +: EXP_BITS]),
        .tol      (tol_reg),
        .sts      (sts),
        .res_re   (res_re),
        .res_im   (res_im),
        .is_equal (is_equal),
        .status   (status)
    );

    // output register, parts the result from the next item's work
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ovalid_reg <= 1'b0;
        else if (done && (!ovalid_reg || m_axis_tready))
            ovalid_reg <= 1'b1;
        else if (m_axis_tready)
            ovalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (done && (!ovalid_reg || m_axis_tready))
            odata_reg <= OW'({status, is_equal, res_im, res_re});
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = odata_reg;

endmodule

>>> hdl/cau_ctrl.sv
// controller state machine for the complex arithmetic unit
// depends on cau_pkg
module cau_ctrl
    import cau_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_fire,
    input  action_t action,
    input  logic    out_free,
    input  sts_t    sts,
    output cmd_t    cmd,
    output logic    busy,
    output logic    done
);

    state_t  state_reg, state_next;
    action_t act_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            act_reg   <= ACT_ADD;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
                act_reg <= action;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    unique case (action)
                        ACT_MUL: state_next = S_MUL;
                        ACT_DIV: state_next = S_DIV_SETUP;
                        ACT_POW: state_next = S_POW_STEP;
                        ACT_MOD: state_next = S_SQRT_SETUP;
                        default: state_next = S_SIMPLE;
                    endcase
                end
            end
            S_SIMPLE, S_MUL: state_next = S_OUT;
            S_DIV_SETUP:  state_next = sts.div_zero ? S_OUT : S_DIV_ITER;
            S_DIV_ITER:   if (sts.iter_done) state_next = S_DIV_DONE;
            S_DIV_DONE:   state_next = S_OUT;
            S_POW_STEP:
            begin
                if (!sts.exp_more)
                    state_next = sts.exp_neg ? S_DIV_SETUP : S_OUT;
                else
                    state_next = S_POW_MUL;
            end
            S_POW_MUL:    state_next = S_POW_STEP;
            S_SQRT_SETUP: state_next = S_SQRT_ITER;
            S_SQRT_ITER:  if (sts.iter_done) state_next = S_OUT;
            S_OUT:        if (out_free) state_next = S_IDLE;
            default:      state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = OP_NONE;
        busy   = 1'b1;
        done   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (in_fire)
                    cmd.op = (action == ACT_POW) ? OP_POW_INIT : OP_LOAD;
            end
            S_SIMPLE:     cmd.op = OP_SIMPLE;
            S_MUL:        cmd.op = OP_MUL_AB;
            S_DIV_SETUP:  cmd.op = (act_reg == ACT_POW) ? OP_DIV_RECIP : OP_DIV_SETUP;
            S_DIV_ITER:   cmd.op = OP_DIV_ITER;
            S_DIV_DONE:   cmd.op = OP_DIV_DONE;
            S_POW_STEP:   cmd.op = sts.exp_bit ? OP_MUL_ZP : OP_POW_SHIFT;
            S_POW_MUL:    cmd.op = OP_MUL_PP;
            S_SQRT_SETUP: cmd.op = OP_SQRT_SETUP;
            S_SQRT_ITER:  cmd.op = OP_SQRT_ITER;
            S_OUT:        done = 1'b1;
            default:      cmd.op = OP_NONE;
        endcase
    end

endmodule

>>> hdl/cau_dp.sv
// datapath of the complex arithmetic unit: operand registers, complex multiply,
// shared restoring divider and square root unit, saturation and result register
// depends on cau_pkg
module cau_dp
    import cau_pkg::*;
#(
    parameter int WORD_BITS = 32,
    parameter int FRAC_BITS = 16,
    parameter int EXP_BITS  = 6
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  cmd_t                        cmd,
    input  logic [2:0]                  action,
    input  logic signed [WORD_BITS-1:0] a_re,
    input  logic signed [WORD_BITS-1:0] a_im,
    input  logic signed [WORD_BITS-1:0] b_re,
    input  logic signed [WORD_BITS-1:0] b_im,
    input  logic signed [EXP_BITS-1:0]  exponent,
    input  logic [15:0]                 tol,
    output sts_t                        sts,
    output logic signed [WORD_BITS-1:0] res_re,
    output logic signed [WORD_BITS-1:0] res_im,
    output logic                        is_equal,
    output logic [1:0]                  status
);

    localparam int W  = WORD_BITS;
    localparam int PW = 2 * W + 2;          // product sum width
    localparam int QW = W + 1;              // quotient bits kept
    localparam int CW = $clog2(PW + QW + 1);
    localparam logic [W-1:0] LIM_POS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] ONE_FX  = W'(1) << FRAC_BITS;

    logic [2:0]          act_reg;
    logic signed [W-1:0] ar_reg, ai_reg, br_reg, bi_reg;
    logic signed [W-1:0] zr_reg, zi_reg;
    logic [EXP_BITS-1:0] em_reg;
    logic                eneg_reg;
    logic                ovf_reg, dz_reg, eq_reg;
    logic signed [W-1:0] rr_reg, ri_reg;
    // divider / root state
    logic [PW-1:0]       nr_reg, ni_reg, d_reg;
    logic                nnr_reg, nni_reg;
    logic [PW-1:0]       rmr_reg, rmi_reg;
    logic [QW-1:0]       qr_reg, qi_reg;
    logic [CW-1:0]       cnt_reg;
    logic [PW-1:0]       sq_reg, rt_reg, bit_reg;

    // saturate sign-magnitude value to word
    function automatic logic [W:0] sat_f(input logic neg, input logic [PW-1:0] mag);
        logic [W-1:0] v;
        logic         o;
        begin
            o = 1'b0;
            if (!neg || mag == '0)
            begin
                if (mag > PW'(LIM_POS)) begin o = 1'b1; v = LIM_POS; end
                else v = mag[W-1:0];
            end
            else
            begin
                if (mag > PW'(LIM_POS) + PW'(1)) begin o = 1'b1; v = ~LIM_POS; end
                else v = W'(-mag);
            end
            return {o, v};
        end
    endfunction

    function automatic logic [PW:0] sm_f(input logic signed [PW-1:0] x);
        begin
            return {x[PW-1], x[PW-1] ? PW'(-x) : PW'(x)};
        end
    endfunction

    // magnitude of a word difference
    function automatic logic [W:0] t_re_diff(input logic signed [W-1:0] x,
                                             input logic signed [W-1:0] y);
        logic signed [W:0] d;
        begin
            d = (W+1)'(x) - (W+1)'(y);
            return d[W] ? (W+1)'(-d) : d;
        end
    endfunction

    // shared complex multiply operands
    logic signed [W-1:0] m_ar, m_ai, m_br, m_bi;
    logic signed [PW-1:0] p_re, p_im;
    logic [PW:0] sm_re, sm_im;
    logic [W:0]  s_re, s_im;

    always_comb
    begin
        m_ar = ar_reg; m_ai = ai_reg; m_br = br_reg; m_bi = bi_reg;
        unique case (cmd.op)
            OP_MUL_ZP:
            begin
                m_ar = zr_reg; m_ai = zi_reg; m_br = ar_reg; m_bi = ai_reg;
            end
            OP_MUL_PP:
            begin
                m_br = ar_reg; m_bi = ai_reg;
            end
            default: ;
        endcase
        p_re  = PW'(m_ar * m_br) - PW'(m_ai * m_bi);
        p_im  = PW'(m_ai * m_br) + PW'(m_ar * m_bi);
        sm_re = sm_f(p_re);
        sm_im = sm_f(p_im);
        s_re  = sat_f(sm_re[PW], sm_re[PW-1:0] >> FRAC_BITS);
        s_im  = sat_f(sm_im[PW], sm_im[PW-1:0] >> FRAC_BITS);
    end

    // add/sub/compare
    logic signed [W:0] sa_re, sa_im;
    logic [W:0] sam_re, sam_im, t_re, t_im;
    always_comb
    begin
        if (act_reg == ACT_ADD)
        begin
            sa_re = (W+1)'(ar_reg) + (W+1)'(br_reg);
            sa_im = (W+1)'(ai_reg) + (W+1)'(bi_reg);
        end
        else
        begin
            sa_re = (W+1)'(ar_reg) - (W+1)'(br_reg);
            sa_im = (W+1)'(ai_reg) - (W+1)'(bi_reg);
        end
        sam_re = sa_re[W] ? (W+1)'(-sa_re) : sa_re;
        sam_im = sa_im[W] ? (W+1)'(-sa_im) : sa_im;
        t_re = sat_f(sa_re[W], PW'(sam_re));
        t_im = sat_f(sa_im[W], PW'(sam_im));
    end

    // divider setup: numerator/denominator from A/B, or 1/Z for power
    logic signed [W-1:0] dn_r, dn_i, dd_r, dd_i;
    logic [W-1:0] mdr, mdi;
    logic [PW-1:0] dsum;
    logic signed [PW-1:0] nx_re, nx_im;
    logic [PW:0] snr, sni;
    always_comb
    begin
        if (cmd.op == OP_DIV_RECIP)
        begin
            dn_r = signed'(ONE_FX); dn_i = '0; dd_r = zr_reg; dd_i = zi_reg;
        end
        else
        begin
            dn_r = ar_reg; dn_i = ai_reg; dd_r = br_reg; dd_i = bi_reg;
        end
        mdr  = dd_r[W-1] ? W'(-dd_r) : W'(dd_r);
        mdi  = dd_i[W-1] ? W'(-dd_i) : W'(dd_i);
        dsum = PW'(mdr * mdr) + PW'(mdi * mdi);
        nx_re = PW'(dn_r * dd_r) + PW'(dn_i * dd_i);
        nx_im = PW'(dn_i * dd_r) - PW'(dn_r * dd_i);
        snr = sm_f(nx_re);
        sni = sm_f(nx_im);
    end

    // restoring division step, numerator bits first then FRAC_BITS zeros
    localparam int STEPS = PW + FRAC_BITS;
    logic [PW:0] tr_re, tr_im;
    logic [PW-1:0] rr_s, ri_s;
    logic qb_re, qb_im;
    always_comb
    begin
        tr_re = {rmr_reg, nr_reg[PW-1]};
        tr_im = {rmi_reg, ni_reg[PW-1]};
        qb_re = tr_re >= {1'b0, d_reg};
        qb_im = tr_im >= {1'b0, d_reg};
        rr_s  = qb_re ? PW'(tr_re - {1'b0, d_reg}) : tr_re[PW-1:0];
        ri_s  = qb_im ? PW'(tr_im - {1'b0, d_reg}) : tr_im[PW-1:0];
    end

    // square root step
    logic [PW-1:0] sq_try, rt_nx;
    logic [W:0]    sq_fin;
    assign sq_try = rt_reg + bit_reg;
    assign rt_nx  = (sq_reg >= sq_try) ? (rt_reg >> 1) + bit_reg : rt_reg >> 1;
    assign sq_fin = sat_f(1'b0, rt_nx);

    logic [W-1:0] mar, mai;
    assign mar = ar_reg[W-1] ? W'(-ar_reg) : W'(ar_reg);
    assign mai = ai_reg[W-1] ? W'(-ai_reg) : W'(ai_reg);

    logic [W:0] q_re_s, q_im_s;
    assign q_re_s = sat_f(nnr_reg, PW'(qr_reg));
    assign q_im_s = sat_f(nni_reg, PW'(qi_reg));

    logic [PW-1:0] dre, dim;
    assign dre = PW'(t_re_diff(ar_reg, br_reg));
    assign dim = PW'(t_re_diff(ai_reg, bi_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (cmd.op == OP_DIV_SETUP || cmd.op == OP_DIV_RECIP)
            cnt_reg <= CW'(STEPS - 1);
        else if (cmd.op == OP_SQRT_SETUP)
            cnt_reg <= CW'(PW / 2 - 1);
        else if ((cmd.op == OP_DIV_ITER || cmd.op == OP_SQRT_ITER) && cnt_reg != '0)
            cnt_reg <= cnt_reg - CW'(1);
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD, OP_POW_INIT:
            begin
                act_reg <= action;
                ar_reg <= a_re; ai_reg <= a_im; br_reg <= b_re; bi_reg <= b_im;
                zr_reg <= signed'(ONE_FX); zi_reg <= '0;
                em_reg <= exponent[EXP_BITS-1] ? EXP_BITS'(-exponent) : exponent;
                eneg_reg <= exponent[EXP_BITS-1];
                ovf_reg <= 1'b0; dz_reg <= 1'b0; eq_reg <= 1'b0;
                rr_reg <= '0; ri_reg <= '0;
            end
            OP_SIMPLE:
            begin
                if (act_reg == ACT_EQ || act_reg == ACT_REQ)
                begin
                    eq_reg <= (dre <= PW'(tol)) &&
                              ((act_reg == ACT_REQ) || dim <= PW'(tol));
                end
                else
                begin
                    rr_reg <= t_re[W-1:0]; ri_reg <= t_im[W-1:0];
                    ovf_reg <= t_re[W] | t_im[W];
                end
            end
            OP_MUL_AB:
            begin
                rr_reg <= s_re[W-1:0]; ri_reg <= s_im[W-1:0];
                ovf_reg <= s_re[W] | s_im[W];
            end
            OP_MUL_ZP:
            begin
                zr_reg <= s_re[W-1:0]; zi_reg <= s_im[W-1:0];
                rr_reg <= s_re[W-1:0]; ri_reg <= s_im[W-1:0];
                ovf_reg <= ovf_reg | s_re[W] | s_im[W];
                em_reg <= em_reg >> 1;
            end
            OP_POW_SHIFT:
                em_reg <= em_reg >> 1;
            OP_MUL_PP:
            begin
                ar_reg <= s_re[W-1:0]; ai_reg <= s_im[W-1:0];
                ovf_reg <= ovf_reg | s_re[W] | s_im[W];
            end
            OP_DIV_SETUP, OP_DIV_RECIP:
            begin
                d_reg <= dsum;
                nr_reg <= snr[PW-1:0]; nnr_reg <= snr[PW];
                ni_reg <= sni[PW-1:0]; nni_reg <= sni[PW];
                rmr_reg <= '0; rmi_reg <= '0; qr_reg <= '0; qi_reg <= '0;
                if (dsum == '0)
                begin
                    dz_reg <= 1'b1; rr_reg <= '0; ri_reg <= '0;
                end
            end
            OP_DIV_ITER:
            begin
                nr_reg <= nr_reg << 1; ni_reg <= ni_reg << 1;
                rmr_reg <= rr_s; rmi_reg <= ri_s;
                // sticky top bit marks a quotient beyond the kept width
                qr_reg <= {qr_reg[QW-1] | qr_reg[QW-2], qr_reg[QW-3:0], qb_re};
                qi_reg <= {qi_reg[QW-1] | qi_reg[QW-2], qi_reg[QW-3:0], qb_im};
            end
            OP_DIV_DONE:
            begin
                rr_reg <= q_re_s[W-1:0]; ri_reg <= q_im_s[W-1:0];
                ovf_reg <= ovf_reg | q_re_s[W] | q_im_s[W];
            end
            OP_SQRT_SETUP:
            begin
                sq_reg  <= PW'(mar * mar) + PW'(mai * mai);
                rt_reg  <= '0;
                bit_reg <= PW'(1) << (2 * (PW / 2 - 1));
            end
            OP_SQRT_ITER:
            begin
                if (sq_reg >= sq_try)
                    sq_reg <= sq_reg - sq_try;
                rt_reg  <= rt_nx;
                bit_reg <= bit_reg >> 2;
                if (cnt_reg == '0)
                begin
                    rr_reg  <= sq_fin[W-1:0];
                    ovf_reg <= sq_fin[W];
                    ri_reg  <= '0;
                end
            end
            default: ;
        endcase
    end

    always_comb
    begin
        sts.iter_done = (cnt_reg == '0);
        sts.div_zero  = (dsum == '0);
        sts.exp_bit   = em_reg[0];
        // exponent bits left after the current one
        sts.exp_more  = (em_reg[EXP_BITS-1:1] != '0);
        sts.exp_neg   = eneg_reg;
    end

    // for a non-negative power the running product is the answer
    assign res_re   = dz_reg ? '0 : (act_reg == ACT_POW && !eneg_reg) ? zr_reg : rr_reg;
    assign res_im   = dz_reg ? '0 : (act_reg == ACT_POW && !eneg_reg) ? zi_reg : ri_reg;
    assign is_equal = eq_reg;
    assign status   = dz_reg ? ST_DZ : (ovf_reg ? ST_OVF : ST_OK);

endmodule

>>> tb/tb_top.sv
// self-checking testbench for the complex arithmetic unit
// predicts every result in-line from the item fields and the tolerance register
// depends on cau_pkg and complex_arithmetic_unit
module tb_top
    import cau_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int W = 32;
    localparam int FB = 16;
    localparam int EB = 6;
    localparam int IN_BITS = ((3+4*W+EB+7)/8)*8;
    localparam int OUT_BITS = ((2*W+3+7)/8)*8;
    localparam longint CYCLE_LIMIT = 2000000;

    // laid out as on the result bus, res_re in the lowest bits
    typedef struct packed {
        logic [1:0]          st;
        logic                eq;
        logic signed [W-1:0] im;
        logic signed [W-1:0] re;
    } cau_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [15:0] cfg_wdata = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_BITS-1:0] s_axis_tdata = '0;   // action, a_re, a_im, b_re, b_im, exponent
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_BITS-1:0] m_axis_tdata;       // res_re, res_im, is_equal, status

    // tolerance as the testbench believes it is
    logic [15:0] tol_model = '0;
    cau_result_t pending_results[$];
    int mismatches = 0;
    int sent_items = 0;
    int checked_results = 0;
    longint cycles = 0;
    int burst_left = 0;
    bit stall_enable = 1'b1;

    complex_arithmetic_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // ---------------- predictor helpers ----------------

    function automatic logic [63:0] mag64(longint x);
        return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // saturate a sign-magnitude value to the word, flagging overflow
    function automatic longint clamp_word(bit neg, logic [63:0] mag, ref bit ovf);
        logic [63:0] lim;
        lim = 64'd1 << (W-1);
        if (!neg || mag == 0)
        begin
            if (mag > lim - 1) begin ovf = 1; mag = lim - 1; end
            return longint'(mag);
        end
        if (mag > lim) begin ovf = 1; mag = lim; end
        return -longint'(mag);
    endfunction

    // exact p + q returned in sign-magnitude form
    function automatic void add_sm(longint p, longint q, output bit neg,
                                   output logic [63:0] mag);
        logic [63:0] mp, mq;
        mp = mag64(p);
        mq = mag64(q);
        if ((p < 0) == (q < 0)) begin neg = p < 0; mag = mp + mq; end
        else if (mp >= mq) begin neg = p < 0; mag = mp - mq; end
        else begin neg = q < 0; mag = mq - mp; end
    endfunction

    function automatic void fx_cmul(longint ar, longint ai, longint br, longint bi,
                                    output longint rr, output longint ri, ref bit ovf);
        bit n;
        logic [63:0] m;
        add_sm(ar*br, -(ai*bi), n, m);
        rr = clamp_word(n, m >> FB, ovf);
        add_sm(ai*br, ar*bi, n, m);
        ri = clamp_word(n, m >> FB, ovf);
    endfunction

    // floor(n * 2^FB / d); an oversize quotient forces saturation
    function automatic logic [63:0] frac_quot(logic [63:0] n, logic [63:0] d);
        logic [63:0] q, r;
        q = n / d;
        r = n % d;
        if (q >= (64'd1 << (W-FB))) return 64'd1 << W;
        for (int i = 0; i < FB; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin r = r - d; q[0] = 1'b1; end
        end
        return q;
    endfunction

    // returns 0 on a zero divisor
    function automatic bit fx_cdiv(longint ar, longint ai, longint br, longint bi,
                                   output longint rr, output longint ri, ref bit ovf);
        logic [63:0] d, m;
        bit n;
        d = mag64(br)*mag64(br) + mag64(bi)*mag64(bi);
        rr = 0;
        ri = 0;
        if (d == 0) return 0;
        add_sm(ar*br, ai*bi, n, m);
        rr = clamp_word(n, frac_quot(m, d), ovf);
        add_sm(ai*br, -(ar*bi), n, m);
        ri = clamp_word(n, frac_quot(m, d), ovf);
        return 1;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b = b >> 2;
        while (b != 0)
        begin
            if (s >= r + b) begin s = s - (r + b); r = (r >> 1) + b; end
            else r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic cau_result_t predict_cau(action_t act, logic signed [W-1:0] a_re,
            logic signed [W-1:0] a_im, logic signed [W-1:0] b_re,
            logic signed [W-1:0] b_im, logic signed [EB-1:0] expo);
        longint ar, ai, br, bi, rr, ri, zr, zi, pr, pi, tr, ti;
        bit ovf, dz, eq;
        int m;
        cau_result_t res;
        ar = a_re; ai = a_im; br = b_re; bi = b_im;
        rr = 0; ri = 0; ovf = 0; dz = 0; eq = 0;
        case (act)
            ACT_ADD:
            begin
                rr = clamp_word(ar+br < 0, mag64(ar+br), ovf);
                ri = clamp_word(ai+bi < 0, mag64(ai+bi), ovf);
            end
            ACT_SUB:
            begin
                rr = clamp_word(ar-br < 0, mag64(ar-br), ovf);
                ri = clamp_word(ai-bi < 0, mag64(ai-bi), ovf);
            end
            ACT_MUL: fx_cmul(ar, ai, br, bi, rr, ri, ovf);
            ACT_DIV: dz = !fx_cdiv(ar, ai, br, bi, rr, ri, ovf);
            ACT_EQ:  eq = mag64(ar-br) <= tol_model && mag64(ai-bi) <= tol_model;
            ACT_REQ: eq = mag64(ar-br) <= tol_model;
            ACT_POW:
            begin
                // square-and-multiply over |exponent|
                m = expo < 0 ? -int'(expo) : int'(expo);
                zr = longint'(1) << FB; zi = 0; pr = ar; pi = ai;
                while (m != 0)
                begin
                    if (m[0]) begin fx_cmul(zr, zi, pr, pi, tr, ti, ovf); zr = tr; zi = ti; end
                    m = m >> 1;
                    if (m != 0) begin fx_cmul(pr, pi, pr, pi, tr, ti, ovf); pr = tr; pi = ti; end
                end
                if (expo < 0) dz = !fx_cdiv(longint'(1) << FB, 0, zr, zi, rr, ri, ovf);
                else begin rr = zr; ri = zi; end
            end
            default: rr = clamp_word(0, int_sqrt(mag64(ar)*mag64(ar) + mag64(ai)*mag64(ai)), ovf);
        endcase
        if (dz) begin rr = 0; ri = 0; end
        res.re = rr[W-1:0];
        res.im = ri[W-1:0];
        res.eq = eq;
        res.st = dz ? ST_DZ : (ovf ? ST_OVF : ST_OK);
        return res;
    endfunction

    // ---------------- driving ----------------

    // send one item, honoring the random burst/gap pattern of the sender
    task automatic send_item(action_t act, logic [W-1:0] a_re, logic [W-1:0] a_im,
                             logic [W-1:0] b_re, logic [W-1:0] b_im, logic [EB-1:0] expo);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= IN_BITS'({expo, b_im, b_re, a_im, a_re, act});
        pending_results.push_back(predict_cau(act, a_re, a_im, b_re, b_im, expo));
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sent_items++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge clk);
        // divide latency covers any work still inside the block
        repeat (120) @(posedge clk);
    endtask

    task automatic write_tolerance(logic [15:0] value);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        tol_model = value;
    endtask

    function automatic logic [W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(0, 8)) - 4) <<< FB;
            3: return 32'($urandom_range(0, 32'h3ffff)) - 32'h2_0000;
            4: return 32'($urandom_range(0, 32'hffffff)) - 32'h80_0000;
            default: return $urandom;
        endcase
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch at result %0d: %s got %0h want %0h",
                 checked_results, what, got, want);
        mismatches++;
    endtask

    // receiver stalls on its own pattern, with quiet stretches
    always @(posedge clk)
    begin
        cycles++;
        if (cycles[9:8] == 2'b11 || !stall_enable) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 3) != 0);
    end

    always @(posedge clk)
    begin
        cau_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[2*W+2:0];
            if (pending_results.size() == 0)
            begin
                report_mismatch("unexpected result", 64'(got.re), 64'd0);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.re !== want.re)
                    report_mismatch("res_re", 64'(got.re), 64'(want.re));
                if (got.im !== want.im)
                    report_mismatch("res_im", 64'(got.im), 64'(want.im));
                if (got.eq !== want.eq)
                    report_mismatch("is_equal", 64'(got.eq), 64'(want.eq));
                if (got.st !== want.st)
                    report_mismatch("status", 64'(got.st), 64'(want.st));
            end
            checked_results++;
        end
    end

    always @(posedge clk)
    begin
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ---------------- tests ----------------

    task automatic test_directed_arith();
        send_item(ACT_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h1, 32'hffff_ffff, '0);
        send_item(ACT_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_ffff, '0);
        send_item(ACT_ADD, 32'h0001_8000, 32'hfffe_0000, 32'h0000_4000, 32'h0003_0000, '0);
        send_item(ACT_MUL, 32'h0002_0000, 32'h0003_0000, 32'hffff_0000, 32'h0004_0000, '0);
        send_item(ACT_MUL, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, '0);
        send_item(ACT_DIV, 32'h0005_0000, 32'h0001_0000, 32'h0, 32'h0, '0);
        send_item(ACT_DIV, 32'h0005_0000, 32'hfffd_0000, 32'h0001_0000, 32'h0002_0000, '0);
        send_item(ACT_DIV, 32'h7fff_ffff, 32'h0, 32'h0000_0001, 32'h0, '0);
        send_item(ACT_MOD, 32'h0003_0000, 32'h0004_0000, '0, '0, '0);
        send_item(ACT_MOD, 32'h8000_0000, 32'h8000_0000, '0, '0, '0);
    endtask

    task automatic test_directed_power();
        send_item(ACT_POW, 32'h0, 32'h0, '0, '0, 6'd0);
        send_item(ACT_POW, 32'h0, 32'h0, '0, '0, 6'h3f);
        send_item(ACT_POW, 32'h0, 32'h0001_0000, '0, '0, 6'd31);
        send_item(ACT_POW, 32'h0001_8000, 32'h0000_8000, '0, '0, 6'd5);
        send_item(ACT_POW, 32'h0002_0000, 32'h0, '0, '0, 6'h20);
        send_item(ACT_POW, 32'h0000_0100, 32'h0, '0, '0, 6'h3e);
        send_item(ACT_POW, 32'h0100_0000, 32'h0, '0, '0, 6'd3);
    endtask

    task automatic test_directed_compare();
        send_item(ACT_EQ, 32'h0001_0000, 32'h5, 32'h0001_0000, 32'h5, '0);
        send_item(ACT_EQ, 32'h0001_0000, 32'h5, 32'h0001_0001, 32'h5, '0);
        send_item(ACT_REQ, 32'h7fff_ffff, 32'h5, 32'h8000_0000, 32'h9, '0);
        write_tolerance(16'hffff);
        send_item(ACT_EQ, 32'h0001_0000, 32'h0, 32'h0001_ffff, 32'hffff_0001, '0);
        send_item(ACT_EQ, 32'h0001_0000, 32'h0, 32'h0002_0000, 32'h0, '0);
        send_item(ACT_REQ, 32'h0, 32'h7, 32'h0000_ffff, 32'h8000_0000, '0);
    endtask

    task automatic test_random(int count);
        action_t act;
        logic [W-1:0] ar, ai, br, bi;
        for (int i = 0; i < count; i++)
        begin
            act = action_t'($urandom_range(0, 7));
            ar = rand_word(); ai = rand_word();
            // half the compares land near their operand so tolerance matters
            if ((act == ACT_EQ || act == ACT_REQ) && $urandom_range(0, 1))
            begin
                br = ar + 32'(int'($urandom_range(0, 2*tol_model+4)) - int'(tol_model) - 2);
                bi = ai + 32'(int'($urandom_range(0, 2*tol_model+4)) - int'(tol_model) - 2);
            end
            else
            begin
                br = ($urandom_range(0, 15) == 0) ? '0 : rand_word();
                bi = ($urandom_range(0, 15) == 0) ? '0 : rand_word();
            end
            send_item(act, ar, ai, br, bi, EB'($urandom));
            if (i == count/2) drain_results();   // sender waits for all results
        end
    endtask

    task automatic test_tolerance_sweep();
        logic [15:0] settings[4] = '{16'h0, 16'h1, 16'h00ff, 16'hffff};
        foreach (settings[k])
        begin
            write_tolerance(settings[k]);
            stall_enable = (k != 2);
            test_random(300);
        end
        stall_enable = 1'b1;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_arith();
        test_directed_power();
        test_directed_compare();
        test_tolerance_sweep();
        test_random(50);
        drain_results();
        $display("sent %0d items, checked %0d results over four tolerance settings",
                 sent_items, checked_results);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
